// File: design/bfnp_pkg.sv
// ----------------------------------------------------------------------------
// bfnp_pkg
// Shared constants for the brute-force nearest point search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfnp_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int COORD_W = 16;
  localparam int POINT_W = 3 * COORD_W;
  localparam int DIST_W  = 32;
  localparam int INDEX_W = 10;

  localparam logic [DIST_W-1:0] RADIUS_SQ_RST = '1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_STORED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: design/bfnp_ram.sv
// ----------------------------------------------------------------------------
// bfnp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfnp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/bfnp_dist.sv
// ----------------------------------------------------------------------------
// bfnp_dist
// Pipelined squared-distance unit: difference, square, saturating sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bfnp_dist
  import bfnp_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [AW-1:0]              in_idx,
  input  wire logic [POINT_W-1:0]         point,
  input  wire logic signed [COORD_W-1:0]  qx,
  input  wire logic signed [COORD_W-1:0]  qy,
  input  wire logic signed [COORD_W-1:0]  qz,
  output logic                            out_valid,
  output logic [AW-1:0]                   out_idx,
  output logic [DIST_W-1:0]               out_dist,
  output logic                            active
);

  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W-1:0]      ax, ay, az;
  logic [2*COORD_W-1:0]    sx, sy, sz;
  logic [DIST_W+1:0]       sum;
  logic                    va, vb;
  logic [AW-1:0]           ia, ib;

  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W:0] d);
    logic signed [COORD_W:0] m;
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

  always_comb begin
    dx  = {qx[COORD_W-1], qx} - {point[3*COORD_W-1], point[3*COORD_W-1:2*COORD_W]};
    dy  = {qy[COORD_W-1], qy} - {point[2*COORD_W-1], point[2*COORD_W-1:COORD_W]};
    dz  = {qz[COORD_W-1], qz} - {point[COORD_W-1], point[COORD_W-1:0]};
    sum = (DIST_W+2)'(sx) + (DIST_W+2)'(sy) + (DIST_W+2)'(sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    ax <= abs_diff(dx);
    ay <= abs_diff(dy);
    az <= abs_diff(dz);
    ia <= in_idx;
    sx <= ax * ax;
    sy <= ay * ay;
    sz <= az * az;
    ib <= ia;
    out_dist <= (sum[DIST_W+1:DIST_W] != 2'b00) ? '1 : sum[DIST_W-1:0];
    out_idx  <= ib;
  end

  assign active = va | vb | out_valid;

endmodule

`default_nettype wire

// File: design/brute_force_nearest_point_top.sv
// ----------------------------------------------------------------------------
// brute_force_nearest_point_top
// Point store with clear, append and brute-force nearest point query.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   command  | start, busy               | op, coord_x, coord_y, coord_z
//   result   | done (one-cycle strobe)   | status, nearest_index, sq_distance
//   config   | cfg_valid, cfg_ready      | cfg_data (radius_sq)
//
// Clear and append keep busy low; the result follows in the next cycle.
// A query holds busy while the store is scanned; one RAM read a cycle feeds
// the shared distance pipeline, and the result follows once it drains.
// Reset empties the store and sets radius_sq to all ones; no clearing pass.
// Results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module brute_force_nearest_point_top
  import bfnp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                op,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [INDEX_W-1:0]             nearest_index,
  output logic [DIST_W-1:0]              sq_distance,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [DIST_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_POINTS);

  state_t state;
  logic [CW-1:0]           point_count;
  logic [CW-1:0]           rd_cnt;
  logic                    rd_valid;
  logic [AW-1:0]           rd_idx;
  logic [DIST_W-1:0]       radius_sq;
  logic signed [COORD_W-1:0] qx, qy, qz;
  logic                    found;
  logic [DIST_W-1:0]       best;
  logic [AW-1:0]           best_idx;
  logic [31:0]             best_idx_wide;
  logic [31:0]             cnt_wide;

  logic                    accept, issue, scan_end, full;
  logic                    ram_we;
  logic [POINT_W-1:0]      rd_data;
  logic                    d_valid, d_active;
  logic [AW-1:0]           d_idx;
  logic [DIST_W-1:0]       d_dist;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (point_count >= COUNT_MAX);
  assign ram_we    = accept && (op == OP_APPEND) && !full;
  assign issue     = (state == S_SCAN) && (rd_cnt < point_count);
  assign scan_end  = (state == S_SCAN) && !issue && !rd_valid && !d_active;
  assign best_idx_wide = 32'(best_idx);
  assign cnt_wide      = 32'(point_count);

  bfnp_ram #(
    .WIDTH(POINT_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(point_count[AW-1:0]),
    .wdata({coord_x, coord_y, coord_z}),
    .raddr(rd_cnt[AW-1:0]),
    .rdata(rd_data)
  );

  bfnp_dist #(
    .AW(AW)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_idx   (rd_idx),
    .point    (rd_data),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .out_valid(d_valid),
    .out_idx  (d_idx),
    .out_dist (d_dist),
    .active   (d_active)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      rd_cnt      <= '0;
      rd_valid    <= 1'b0;
      found       <= 1'b0;
      done        <= 1'b0;
      radius_sq   <= RADIUS_SQ_RST;
    end else begin
      done     <= (accept && (op == OP_CLEAR || op == OP_APPEND)) || scan_end;
      rd_valid <= issue;
      if (cfg_valid && cfg_ready) begin
        radius_sq <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_CLEAR: begin
                point_count <= '0;
              end
              OP_APPEND: begin
                if (!full) begin
                  point_count <= point_count + 1'b1;
                end
              end
              OP_QUERY: begin
                rd_cnt <= '0;
                found  <= 1'b0;
                state  <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (d_valid && (!found || d_dist < best)) begin
            found <= 1'b1;
          end
          if (scan_end) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx <= rd_cnt[AW-1:0];
    if (accept && op == OP_QUERY) begin
      qx <= coord_x;
      qy <= coord_y;
      qz <= coord_z;
    end
    if (state == S_SCAN && d_valid && (!found || d_dist < best)) begin
      best     <= d_dist;
      best_idx <= d_idx;
    end
    if (accept) begin
      sq_distance <= '0;
      if (op == OP_APPEND && !full) begin
        status        <= ST_STORED;
        nearest_index <= cnt_wide[INDEX_W-1:0];
      end else begin
        status        <= (op == OP_APPEND) ? ST_FULL : ST_CLEARED;
        nearest_index <= '0;
      end
    end else if (scan_end) begin
      if (found && best < radius_sq) begin
        status        <= ST_HIT;
        nearest_index <= best_idx_wide[INDEX_W-1:0];
        sq_distance   <= best;
      end else begin
        status        <= ST_MISS;
        nearest_index <= '0;
        sq_distance   <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= COUNT_MAX)
    else $error("point count beyond store depth");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    (rd_valid || d_active) |-> (state == S_SCAN))
    else $error("distance pipeline active outside a scan");

  a_hit_in_radius: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_HIT) |-> (sq_distance < radius_sq))
    else $error("hit reported outside radius");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_MISS || status == ST_FULL || status == ST_CLEARED))
      |-> (sq_distance == '0 && nearest_index == '0))
    else $error("non-zero fields on miss, full or clear");

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_SCAN && state == S_IDLE) |-> done)
    else $error("scan ended without a result");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Nearest point search: directed and random clear, append, query and unused-op
// items with random start gaps, checked against a behavioural copy of the point
// store; the search radius is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import bfnp_pkg::*;

  localparam int         STORE_DEPTH = MAX_POINTS_DEF;
  localparam int         PHASE_ITEMS = 108;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0] op;
    point_t     pt;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } result_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      start     = 1'b0;
  logic [1:0]                op        = OP_CLEAR;
  logic signed [COORD_W-1:0] coord_x   = '0;
  logic signed [COORD_W-1:0] coord_y   = '0;
  logic signed [COORD_W-1:0] coord_z   = '0;
  logic                      cfg_valid = 1'b0;
  logic [DIST_W-1:0]         cfg_data  = '0;
  logic                      busy;
  logic                      done;
  logic                      cfg_ready;
  logic [2:0]                status;
  logic [INDEX_W-1:0]        nearest_index;
  logic [DIST_W-1:0]         sq_distance;

  point_t            held_pts[STORE_DEPTH];
  int                held_count = 0;
  logic [DIST_W-1:0] radius_sq  = RADIUS_SQ_RST;
  result_t           search_results_q[$];
  cmd_t              pending_q[$];
  point_t            gen_pts[$];
  int                mismatches = 0;
  int                gap_left   = 0;
  int                calm_left  = 0;

  brute_force_nearest_point_top #(
    .MAX_POINTS(STORE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .done(done),
    .status(status),
    .nearest_index(nearest_index),
    .sq_distance(sq_distance),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DIST_W-1:0] sq_dist(input point_t a, input point_t b);
    longint dx, dy, dz, s;
    dx = $signed(a.x) - $signed(b.x);
    dy = $signed(a.y) - $signed(b.y);
    dz = $signed(a.z) - $signed(b.z);
    s  = dx * dx + dy * dy + dz * dz;
    if (s > 64'sh0000_0000_FFFF_FFFF) return '1;
    return s[DIST_W-1:0];
  endfunction

  task automatic model_item(input cmd_t c);
    result_t           r;
    logic [DIST_W-1:0] best, d;
    int                best_i;
    logic              found;
    r = '0;
    case (c.op)
      OP_CLEAR: begin
        held_count = 0;
        r.status   = ST_CLEARED;
      end
      OP_APPEND: begin
        if (held_count >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_pts[held_count] = c.pt;
          r.status = ST_STORED;
          r.index  = held_count[INDEX_W-1:0];
          held_count++;
        end
      end
      OP_QUERY: begin
        found  = 1'b0;
        best   = '1;
        best_i = 0;
        for (int i = 0; i < held_count; i++) begin
          d = sq_dist(c.pt, held_pts[i]);
          if (!found || d < best) begin
            best   = d;
            best_i = i;
            found  = 1'b1;
          end
        end
        if (found && best < radius_sq) begin
          r.status   = ST_HIT;
          r.index    = best_i[INDEX_W-1:0];
          r.distance = best;
        end else begin
          r.status = ST_MISS;
        end
      end
      default: return;
    endcase
    search_results_q.push_back(r);
  endtask

  function automatic int next_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7, 8:    return $urandom_range(1, 3);
      default:       return $urandom_range(8, 30);
    endcase
  endfunction

  always @(posedge clk) begin : drive_items
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        c        = pending_q.pop_front();
        start    <= 1'b1;
        op       <= c.op;
        coord_x  <= c.pt.x;
        coord_y  <= c.pt.y;
        coord_z  <= c.pt.z;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    cmd_t    c;
    result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) radius_sq = cfg_data;
      if (start && !busy) begin
        c.op   = op;
        c.pt.x = coord_x;
        c.pt.y = coord_y;
        c.pt.z = coord_z;
        model_item(c);
      end
      if (done) begin
        if (search_results_q.size() == 0) begin
          $display("%0t: unexpected result: status %0d index %0d distance %h",
                   $time, status, nearest_index, sq_distance);
          mismatches++;
        end else begin
          want = search_results_q.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
          if (nearest_index !== want.index) begin
            $display("%0t: nearest_index expected %0d actual %0d",
                     $time, want.index, nearest_index);
            mismatches++;
          end
          if (sq_distance !== want.distance) begin
            $display("%0t: sq_distance expected %h actual %h",
                     $time, want.distance, sq_distance);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic point_t mk_point(input int x, input int y, input int z);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    return p;
  endfunction

  function automatic point_t sphere_point();
    return mk_point(int'($urandom_range(0, 32768)) - 16384,
                    int'($urandom_range(0, 32768)) - 16384,
                    int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic point_t raw_point();
    return mk_point($urandom(), $urandom(), $urandom());
  endfunction

  function automatic point_t near_point(input int spread);
    point_t p;
    if (gen_pts.size() == 0) return sphere_point();
    p = gen_pts[$urandom_range(0, gen_pts.size() - 1)];
    p.x = p.x + COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
    p.y = p.y + COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
    p.z = p.z + COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
    return p;
  endfunction

  task automatic push_item(input logic [1:0] kind, input point_t p);
    cmd_t c;
    c.op = kind;
    c.pt = p;
    pending_q.push_back(c);
    if (kind == OP_CLEAR) gen_pts.delete();
    else if (kind == OP_APPEND && gen_pts.size() < STORE_DEPTH) gen_pts.push_back(p);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || busy || search_results_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_radius(input logic [DIST_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int budget);
    int     sent;
    int     n;
    point_t p;
    sent = 0;
    while (sent < budget) begin
      if (gen_pts.size() > 48 || $urandom_range(0, 2) == 0) begin
        push_item(OP_CLEAR, raw_point());
        sent++;
      end
      n = $urandom_range(0, 10);
      repeat (n) begin
        if (gen_pts.size() != 0 && $urandom_range(0, 7) == 0) p = near_point(0);
        else if ($urandom_range(0, 7) == 0) p = raw_point();
        else p = sphere_point();
        push_item(OP_APPEND, p);
        sent++;
      end
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1:    p = near_point(0);
          2, 3, 4: p = near_point(512);
          5, 6, 7: p = sphere_point();
          default: p = raw_point();
        endcase
        push_item(OP_QUERY, p);
        sent++;
      end
      if ($urandom_range(0, 4) == 0) push_item(OP_UNUSED, raw_point());
    end
  endtask

  initial begin : stimulus
    logic [DIST_W-1:0] radii[5];
    radii = '{32'h0010_0000, 32'h0400_0000, 32'h1000_0000, $urandom(), 32'hFFFF_FFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_item(OP_QUERY, mk_point(0, 0, 0));
    push_item(OP_UNUSED, mk_point(-1, -1, -1));
    push_item(OP_APPEND, mk_point(-16384, -16384, -16384));
    push_item(OP_QUERY, mk_point(16384, 16384, 16384));
    push_item(OP_APPEND, mk_point(16384, 16384, 16384));
    push_item(OP_APPEND, mk_point(0, 0, 0));
    push_item(OP_APPEND, mk_point(0, 0, 0));
    push_item(OP_QUERY, mk_point(0, 0, 0));
    push_item(OP_QUERY, mk_point(-16384, 16384, -16384));
    push_item(OP_CLEAR, mk_point(-1, -1, -1));
    push_item(OP_APPEND, mk_point(-32768, -32768, -32768));
    push_item(OP_QUERY, mk_point(32767, 32767, 32767));
    push_item(OP_QUERY, mk_point(-32768, -32768, -32768));
    push_item(OP_CLEAR, mk_point(0, 0, 0));
    push_item(OP_APPEND, mk_point(0, 0, 0));
    wait_idle();
    write_radius(32'h0400_0000);
    push_item(OP_QUERY, mk_point(8192, 0, 0));
    push_item(OP_QUERY, mk_point(0, -8191, 0));
    wait_idle();
    write_radius('0);
    push_item(OP_QUERY, mk_point(0, 0, 0));
    wait_idle();
    write_radius('1);

    foreach (radii[k]) begin
      wait_idle();
      write_radius(radii[k]);
      random_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && search_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
